[rtl/cca_pkg.sv]
// Shared types and constants of the chained chunk allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package cca_pkg;

  localparam int MEM_BYTES_DEF    = 4096;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int ADDR_W           = 18;
  localparam int LINK_W           = 16;
  localparam int SIZE_W           = 17;

  localparam logic [LINK_W-1:0] NULL_LINK = 16'hFFFF;
  localparam logic [LINK_W-1:0] LAST_LINK = 16'hFFFE;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_FREE    = 3'd1;
  localparam logic [2:0] CMD_REALLOC = 3'd2;
  localparam logic [2:0] CMD_LOCATE  = 3'd3;
  localparam logic [2:0] CMD_NEXT    = 3'd4;
  localparam logic [2:0] CMD_ATTACH  = 3'd5;
  localparam logic [2:0] CMD_DETACH  = 3'd6;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_READ, OP_READ_TAIL,
    OP_A_SKIP, OP_A_TAKE, OP_A_MARK, OP_A_LINK, OP_R_START,
    OP_F_MARK, OP_C_START, OP_C_FREE, OP_C_FOLLOW, OP_C_MERGE,
    OP_C_CHAIN, OP_E_STEP, OP_E_ALLOC, OP_E_LINK, OP_L_STEP,
    OP_T_WRITE, OP_FIN_FAIL, OP_FIN_OK, OP_FIN_FREE, OP_FIN_ALLOC,
    OP_FIN_NULL, OP_FIN_LOC, OP_FIN_NEXT, OP_FIN_NEXT_BAD, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       a_valid;
    logic       blk_special;
    logic       size_nz;
    logic       hdr_free;
    logic       fit;
    logic       cont;
    logic       result_none;
    logic       follow_merge;
    logic       steps_max;
    logic       loc_hit;
    logic       found;
    logic       clr_last;
    logic       out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/cca_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; holds the chunk arena.
`default_nettype none

module cca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/cca_dp.sv]
// Datapath of the allocator: walk registers, header arithmetic, arena port
// control and the result register. Depends on cca_pkg; driven by cca_ctrl.
`default_nettype none

module cca_dp #(
  parameter int MEM_BYTES    = cca_pkg::MEM_BYTES_DEF,
  parameter int HEADER_BYTES = cca_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  cca_pkg::dp_op_t                            op,
  output cca_pkg::dp_stat_t                          stat,
  input  wire logic [2:0]                            in_cmd,
  input  wire logic [15:0]                           in_block,
  input  wire logic [15:0]                           in_second_block,
  input  wire logic [12:0]                           in_size,
  input  wire logic                                  in_contiguous,
  input  wire logic [11:0]                           in_offset,
  input  wire logic                                  out_tready,
  output logic                                       out_tvalid,
  output logic [15:0]                                out_address,
  output logic                                       out_ok,
  output logic                                       ram_we,
  output logic [$clog2(MEM_BYTES/4)-1:0]             ram_waddr,
  output logic [31:0]                                ram_wdata,
  output logic                                       ram_re,
  output logic [$clog2(MEM_BYTES/4)-1:0]             ram_raddr,
  input  wire logic [31:0]                           ram_rdata
);

  import cca_pkg::*;

  localparam int WORDS      = MEM_BYTES / 4;
  localparam int IW         = $clog2(WORDS);
  localparam int WALK_LIMIT = MEM_BYTES / 4 + 1;
  localparam int SW         = $clog2(WALK_LIMIT + 1);
  localparam logic [ADDR_W-1:0] HB_A    = ADDR_W'(HEADER_BYTES);
  localparam logic [15:0]       HB_S    = 16'(HEADER_BYTES);
  localparam logic [15:0]       MIN_S   = 16'(HEADER_BYTES + 4);
  localparam logic [15:0]       INIT_SZ = 16'(MEM_BYTES - HEADER_BYTES);

  function automatic logic addr_ok(input logic [ADDR_W-1:0] x);
    return (x[1:0] == 2'b00) &&
           (({1'b0, x} + (ADDR_W+1)'(HEADER_BYTES)) <= (ADDR_W+1)'(MEM_BYTES));
  endfunction

  function automatic logic [SIZE_W-1:0] round4(input logic [SIZE_W-1:0] s);
    return (s[1:0] != 2'b00) ? {s[SIZE_W-1:2] + 1'b1, 2'b00} : s;
  endfunction

  logic [ADDR_W-1:0] a_r, a_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [11:0]       off_r, off_nxt;
  logic [15:0]       blk2_r, blk2_nxt;
  logic              cont_r, cont_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [15:0]       result_r, result_nxt;
  logic [15:0]       prev_r, prev_nxt;
  logic [15:0]       prev_sz_r, prev_sz_nxt;
  logic [15:0]       fh_r, fh_nxt;
  logic [15:0]       fh_sz_r, fh_sz_nxt;
  logic              have_free_r, have_free_nxt;
  logic [15:0]       tail_r, tail_nxt;
  logic              found_r, found_nxt;
  logic [SW-1:0]     steps_r, steps_nxt;
  logic              started_r, started_nxt;
  logic [15:0]       sz_r, sz_nxt;
  logic [15:0]       addr_r, addr_nxt;
  logic              ok_r, ok_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_addr_r, out_addr_nxt;
  logic              out_ok_r, out_ok_nxt;

  logic [15:0]       hdr_sz;
  logic [15:0]       hdr_nx;
  logic [ADDR_W-1:0] follow;
  logic [ADDR_W-1:0] split;
  logic [15:0]       rest;
  logic              fit;
  logic              can_split;
  logic [15:0]       merged;
  logic [15:0]       fh_grown;

  assign hdr_sz    = ram_rdata[15:0];
  assign hdr_nx    = ram_rdata[31:16];
  assign follow    = a_r + HB_A + ADDR_W'(hdr_sz);
  assign split     = a_r + HB_A + ADDR_W'(size_r);
  assign fit       = {1'b0, hdr_sz} >= size_r;
  assign rest      = hdr_sz - size_r[15:0];
  assign can_split = (rest >= MIN_S) && addr_ok(split);
  assign merged    = sz_r + HB_S + hdr_sz;
  assign fh_grown  = fh_sz_r + HB_S + hdr_sz;

  always_comb begin
    stat.cmd          = cmd_r;
    stat.a_valid      = addr_ok(a_r);
    stat.blk_special  = (a_r == ADDR_W'(NULL_LINK)) || (a_r == ADDR_W'(LAST_LINK));
    stat.size_nz      = size_r != '0;
    stat.hdr_free     = hdr_nx == NULL_LINK;
    stat.fit          = fit;
    stat.cont         = cont_r;
    stat.result_none  = result_r == NULL_LINK;
    stat.follow_merge = (ADDR_W'(hdr_nx) == follow) && addr_ok(follow);
    stat.steps_max    = steps_r >= SW'(WALK_LIMIT);
    stat.loc_hit      = hdr_sz > {4'b0, off_r};
    stat.found        = found_r;
    stat.clr_last     = clr_r == IW'(WORDS - 1);
    stat.out_busy     = out_valid_r && !out_tready;
  end

  always_comb begin
    a_nxt         = a_r;
    size_nxt      = size_r;
    off_nxt       = off_r;
    blk2_nxt      = blk2_r;
    cont_nxt      = cont_r;
    cmd_nxt       = cmd_r;
    result_nxt    = result_r;
    prev_nxt      = prev_r;
    prev_sz_nxt   = prev_sz_r;
    fh_nxt        = fh_r;
    fh_sz_nxt     = fh_sz_r;
    have_free_nxt = have_free_r;
    tail_nxt      = tail_r;
    found_nxt     = found_r;
    steps_nxt     = steps_r;
    started_nxt   = started_r;
    sz_nxt        = sz_r;
    addr_nxt      = addr_r;
    ok_nxt        = ok_r;
    clr_nxt       = clr_r;
    out_addr_nxt  = out_addr_r;
    out_ok_nxt    = out_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_waddr     = a_r[IW+1:2];
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = a_r[IW+1:2];

    case (op)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = (clr_r == '0) ? {NULL_LINK, INIT_SZ} : '0;
        clr_nxt   = clr_r + 1'b1;
      end
      OP_LOAD: begin
        cmd_nxt     = in_cmd;
        a_nxt       = (in_cmd == CMD_ALLOC) ? '0 : ADDR_W'(in_block);
        size_nxt    = (in_cmd == CMD_ALLOC) ? round4(SIZE_W'(in_size)) : SIZE_W'(in_size);
        blk2_nxt    = in_second_block;
        cont_nxt    = in_contiguous;
        off_nxt     = in_offset;
        result_nxt  = NULL_LINK;
        prev_nxt    = NULL_LINK;
        steps_nxt   = '0;
        found_nxt   = 1'b0;
        started_nxt = addr_ok(ADDR_W'(in_block));
        addr_nxt    = '0;
        ok_nxt      = 1'b0;
      end
      OP_READ: begin
        ram_re = 1'b1;
      end
      OP_READ_TAIL: begin
        ram_re    = 1'b1;
        ram_raddr = tail_r[IW+1:2];
      end
      OP_A_SKIP: begin
        a_nxt = follow;
      end
      OP_A_TAKE: begin
        if (fit && can_split) begin
          ram_we    = 1'b1;
          ram_waddr = split[IW+1:2];
          ram_wdata = {NULL_LINK, rest - HB_S};
          sz_nxt    = size_r[15:0];
        end else begin
          sz_nxt    = hdr_sz;
        end
        size_nxt = fit ? '0 : size_r - SIZE_W'(hdr_sz);
      end
      OP_A_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = {LAST_LINK, sz_r};
        if (result_r == NULL_LINK) begin
          result_nxt = a_r[15:0];
        end
      end
      OP_A_LINK: begin
        if (prev_r != NULL_LINK) begin
          ram_we    = 1'b1;
          ram_waddr = prev_r[IW+1:2];
          ram_wdata = {a_r[15:0], prev_sz_r};
        end
        prev_nxt    = a_r[15:0];
        prev_sz_nxt = sz_r;
        a_nxt       = a_r + HB_A + ADDR_W'(sz_r);
      end
      OP_R_START: begin
        a_nxt = ADDR_W'(result_r);
      end
      OP_F_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = {NULL_LINK, hdr_sz};
        a_nxt     = ADDR_W'(hdr_nx);
      end
      OP_C_START: begin
        a_nxt         = '0;
        have_free_nxt = 1'b0;
      end
      OP_C_FREE: begin
        if (!have_free_r) begin
          have_free_nxt = 1'b1;
          fh_nxt        = a_r[15:0];
          fh_sz_nxt     = hdr_sz;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = fh_r[IW+1:2];
          ram_wdata = {NULL_LINK, fh_grown};
          fh_sz_nxt = fh_grown;
        end
        a_nxt = follow;
      end
      OP_C_FOLLOW: begin
        have_free_nxt = 1'b0;
        sz_nxt        = hdr_sz;
        ram_re        = 1'b1;
        ram_raddr     = follow[IW+1:2];
      end
      OP_C_MERGE: begin
        ram_we    = 1'b1;
        ram_wdata = {hdr_nx, merged};
        a_nxt     = a_r + HB_A + ADDR_W'(merged);
      end
      OP_C_CHAIN: begin
        have_free_nxt = 1'b0;
        a_nxt         = follow;
      end
      OP_E_STEP: begin
        steps_nxt = steps_r + 1'b1;
        tail_nxt  = a_r[15:0];
        found_nxt = 1'b1;
        size_nxt  = (size_r > SIZE_W'(hdr_sz)) ? size_r - SIZE_W'(hdr_sz) : '0;
        a_nxt     = ADDR_W'(hdr_nx);
      end
      OP_E_ALLOC: begin
        a_nxt      = '0;
        size_nxt   = round4(size_r);
        cont_nxt   = 1'b0;
        result_nxt = NULL_LINK;
        prev_nxt   = NULL_LINK;
      end
      OP_E_LINK: begin
        ram_we        = 1'b1;
        ram_waddr     = tail_r[IW+1:2];
        ram_wdata     = {result_r, hdr_sz};
        a_nxt         = '0;
        have_free_nxt = 1'b0;
      end
      OP_L_STEP: begin
        off_nxt   = off_r - hdr_sz[11:0];
        a_nxt     = ADDR_W'(hdr_nx);
        steps_nxt = steps_r + 1'b1;
      end
      OP_T_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = {(cmd_r == CMD_ATTACH) ? blk2_r : LAST_LINK, hdr_sz};
        addr_nxt  = '0;
        ok_nxt    = 1'b1;
      end
      OP_FIN_FAIL: begin
        addr_nxt = '0;
        ok_nxt   = 1'b0;
      end
      OP_FIN_OK: begin
        addr_nxt = '0;
        ok_nxt   = 1'b1;
      end
      OP_FIN_FREE: begin
        addr_nxt = '0;
        ok_nxt   = started_r;
      end
      OP_FIN_ALLOC: begin
        if (size_r == '0) begin
          addr_nxt = result_r;
          ok_nxt   = result_r != NULL_LINK;
        end else begin
          addr_nxt = NULL_LINK;
          ok_nxt   = 1'b0;
        end
      end
      OP_FIN_NULL: begin
        addr_nxt = NULL_LINK;
        ok_nxt   = 1'b0;
      end
      OP_FIN_LOC: begin
        addr_nxt = a_r[15:0] + HB_S + {4'b0, off_r};
        ok_nxt   = 1'b1;
      end
      OP_FIN_NEXT: begin
        addr_nxt = ((hdr_nx == LAST_LINK) || (hdr_nx == NULL_LINK)) ? LAST_LINK : hdr_nx;
        ok_nxt   = 1'b1;
      end
      OP_FIN_NEXT_BAD: begin
        addr_nxt = LAST_LINK;
        ok_nxt   = 1'b0;
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_addr_nxt  = addr_r;
        out_ok_nxt    = ok_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r         <= a_nxt;
    size_r      <= size_nxt;
    off_r       <= off_nxt;
    blk2_r      <= blk2_nxt;
    cont_r      <= cont_nxt;
    cmd_r       <= cmd_nxt;
    result_r    <= result_nxt;
    prev_r      <= prev_nxt;
    prev_sz_r   <= prev_sz_nxt;
    fh_r        <= fh_nxt;
    fh_sz_r     <= fh_sz_nxt;
    have_free_r <= have_free_nxt;
    tail_r      <= tail_nxt;
    found_r     <= found_nxt;
    steps_r     <= steps_nxt;
    started_r   <= started_nxt;
    sz_r        <= sz_nxt;
    addr_r      <= addr_nxt;
    ok_r        <= ok_nxt;
    out_addr_r  <= out_addr_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign out_address = out_addr_r;
  assign out_ok      = out_ok_r;

endmodule

`default_nettype wire

[rtl/cca_ctrl.sv]
// Controller of the allocator: sequences header walks, splits, releases and
// the coalescing pass. Depends on cca_pkg; commands cca_dp.
`default_nettype none

module cca_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  cca_pkg::dp_stat_t stat,
  output cca_pkg::dp_op_t   op
);

  import cca_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_A_LOOP, S_A_EVAL, S_A_MARK, S_A_LINK,
    S_F_LOOP, S_F_EVAL, S_C_LOOP, S_C_EVAL, S_C_MERGE, S_E_LOOP, S_E_EVAL,
    S_E_LINK, S_L_LOOP, S_L_EVAL, S_N_EVAL, S_T_EVAL, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    CTX_ALLOC, CTX_FREE, CTX_EXT, CTX_EXT_FAIL, CTX_EXT_OK
  } ctx_t;

  state_t state_r, state_nxt;
  ctx_t   ctx_r, ctx_nxt;

  always_comb begin
    op        = OP_NONE;
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    case (state_r)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op        = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.cmd)
          CMD_ALLOC: begin
            ctx_nxt   = CTX_ALLOC;
            state_nxt = S_A_LOOP;
          end
          CMD_FREE: begin
            if (stat.blk_special) begin
              op        = OP_FIN_FAIL;
              state_nxt = S_DONE;
            end else begin
              ctx_nxt   = CTX_FREE;
              state_nxt = S_F_LOOP;
            end
          end
          CMD_REALLOC: state_nxt = S_E_LOOP;
          CMD_LOCATE:  state_nxt = S_L_LOOP;
          CMD_NEXT: begin
            if (stat.a_valid) begin
              op        = OP_READ;
              state_nxt = S_N_EVAL;
            end else begin
              op        = OP_FIN_NEXT_BAD;
              state_nxt = S_DONE;
            end
          end
          CMD_ATTACH, CMD_DETACH: begin
            if (stat.a_valid) begin
              op        = OP_READ;
              state_nxt = S_T_EVAL;
            end else begin
              op        = OP_FIN_FAIL;
              state_nxt = S_DONE;
            end
          end
          default: begin
            op        = OP_FIN_FAIL;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_A_LOOP: begin
        if (stat.size_nz && stat.a_valid) begin
          op        = OP_READ;
          state_nxt = S_A_EVAL;
        end else if (stat.size_nz && !stat.result_none) begin
          op        = OP_R_START;
          ctx_nxt   = (ctx_r == CTX_EXT) ? CTX_EXT_FAIL : CTX_ALLOC;
          state_nxt = S_F_LOOP;
        end else if (ctx_r == CTX_EXT) begin
          if (stat.size_nz) begin
            op        = OP_FIN_FAIL;
            state_nxt = S_DONE;
          end else begin
            op        = OP_READ_TAIL;
            state_nxt = S_E_LINK;
          end
        end else begin
          op        = OP_FIN_ALLOC;
          state_nxt = S_DONE;
        end
      end
      S_A_EVAL: begin
        if (stat.hdr_free && (stat.fit || !stat.cont)) begin
          op        = OP_A_TAKE;
          state_nxt = S_A_MARK;
        end else begin
          op        = OP_A_SKIP;
          state_nxt = S_A_LOOP;
        end
      end
      S_A_MARK: begin
        op        = OP_A_MARK;
        state_nxt = S_A_LINK;
      end
      S_A_LINK: begin
        op        = OP_A_LINK;
        state_nxt = S_A_LOOP;
      end
      S_F_LOOP: begin
        if (stat.a_valid) begin
          op        = OP_READ;
          state_nxt = S_F_EVAL;
        end else begin
          op        = OP_C_START;
          state_nxt = S_C_LOOP;
        end
      end
      S_F_EVAL: begin
        op        = OP_F_MARK;
        state_nxt = S_F_LOOP;
      end
      S_C_LOOP: begin
        if (stat.a_valid) begin
          op        = OP_READ;
          state_nxt = S_C_EVAL;
        end else begin
          case (ctx_r)
            CTX_FREE:     op = OP_FIN_FREE;
            CTX_ALLOC:    op = OP_FIN_ALLOC;
            CTX_EXT_FAIL: op = OP_FIN_FAIL;
            default:      op = OP_FIN_OK;
          endcase
          state_nxt = S_DONE;
        end
      end
      S_C_EVAL: begin
        if (stat.hdr_free) begin
          op        = OP_C_FREE;
          state_nxt = S_C_LOOP;
        end else if (stat.follow_merge) begin
          op        = OP_C_FOLLOW;
          state_nxt = S_C_MERGE;
        end else begin
          op        = OP_C_CHAIN;
          state_nxt = S_C_LOOP;
        end
      end
      S_C_MERGE: begin
        op        = OP_C_MERGE;
        state_nxt = S_C_LOOP;
      end
      S_E_LOOP: begin
        if (stat.a_valid) begin
          if (stat.steps_max) begin
            op        = OP_FIN_FAIL;
            state_nxt = S_DONE;
          end else begin
            op        = OP_READ;
            state_nxt = S_E_EVAL;
          end
        end else if (!stat.found) begin
          op        = OP_FIN_FAIL;
          state_nxt = S_DONE;
        end else if (stat.size_nz) begin
          op        = OP_E_ALLOC;
          ctx_nxt   = CTX_EXT;
          state_nxt = S_A_LOOP;
        end else begin
          op        = OP_C_START;
          ctx_nxt   = CTX_EXT_OK;
          state_nxt = S_C_LOOP;
        end
      end
      S_E_EVAL: begin
        op        = OP_E_STEP;
        state_nxt = S_E_LOOP;
      end
      S_E_LINK: begin
        op        = OP_E_LINK;
        ctx_nxt   = CTX_EXT_OK;
        state_nxt = S_C_LOOP;
      end
      S_L_LOOP: begin
        if (stat.a_valid && !stat.steps_max) begin
          op        = OP_READ;
          state_nxt = S_L_EVAL;
        end else begin
          op        = OP_FIN_NULL;
          state_nxt = S_DONE;
        end
      end
      S_L_EVAL: begin
        if (stat.loc_hit) begin
          op        = OP_FIN_LOC;
          state_nxt = S_DONE;
        end else begin
          op        = OP_L_STEP;
          state_nxt = S_L_LOOP;
        end
      end
      S_N_EVAL: begin
        op        = OP_FIN_NEXT;
        state_nxt = S_DONE;
      end
      S_T_EVAL: begin
        op        = OP_T_WRITE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          op        = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ctx_r   <= CTX_ALLOC;
    end else begin
      state_r <= state_nxt;
      ctx_r   <= ctx_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

endmodule

`default_nettype wire

[rtl/chained_chunk_allocator_top.sv]
// Top level of the chained chunk allocator: controller, datapath and arena RAM.
// Depends on cca_pkg, cca_ram, cca_dp and cca_ctrl.
//
//   channel  direction  contents
//   in_*     slave      one command beat: cmd in tuser, operands in tdata
//   out_*    master     one result beat: address and ok in tdata
//
// After reset the arena is cleared one word a cycle, with in_tready low. A
// command then walks chunk headers; free, a realloc that succeeds or releases
// partly taken chunks, and an alloc that fails after taking chunks also run a
// coalescing pass over every chunk, so time depends on the arena contents.
// The single arena read port paces the walks. A finished result waits in
// the output register while the next command is accepted and processed.
`default_nettype none

module chained_chunk_allocator_top #(
  parameter int MEM_BYTES    = cca_pkg::MEM_BYTES_DEF,
  parameter int HEADER_BYTES = cca_pkg::HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // block[15:0], second_block[31:16], size[44:32], contiguous[45], offset[57:46]
  input  wire logic [63:0] in_tdata,
  // cmd[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // address[15:0], ok[16]
  output logic [23:0]      out_tdata
);

  import cca_pkg::*;

  localparam int WORDS = MEM_BYTES / 4;
  localparam int IW    = $clog2(WORDS);

  dp_op_t   op;
  dp_stat_t stat;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [15:0]   out_address;
  logic          out_ok;

  cca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .op        (op)
  );

  cca_dp #(
    .MEM_BYTES    (MEM_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .stat            (stat),
    .in_cmd          (in_tuser),
    .in_block        (in_tdata[15:0]),
    .in_second_block (in_tdata[31:16]),
    .in_size         (in_tdata[44:32]),
    .in_contiguous   (in_tdata[45]),
    .in_offset       (in_tdata[57:46]),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_address     (out_address),
    .out_ok          (out_ok),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  cca_ram #(
    .WIDTH (32),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = {7'b0, out_ok, out_address};

endmodule

`default_nettype wire
